// ===== design/tdn_pkg.sv =====
package tdn_pkg;

  // TELNET command and option codes
  localparam logic [7:0] CmdSe   = 8'd240;
  localparam logic [7:0] CmdSb   = 8'd250;
  localparam logic [7:0] CmdWill = 8'd251;
  localparam logic [7:0] CmdWont = 8'd252;
  localparam logic [7:0] CmdDo   = 8'd253;
  localparam logic [7:0] CmdDont = 8'd254;
  localparam logic [7:0] CmdIac  = 8'd255;
  localparam logic [7:0] OptEcho = 8'd1;
  localparam logic [7:0] OptSga  = 8'd3;

  // NVT line-ending characters
  localparam logic [7:0] ChNul = 8'd0;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChCr  = 8'd13;

  // Option store geometry and flag bit positions
  localparam int unsigned NumOpts  = 256;
  localparam int unsigned FlagW    = 4;
  localparam int unsigned FlagHim     = 0;
  localparam int unsigned FlagHimTold = 1;
  localparam int unsigned FlagUs      = 2;
  localparam int unsigned FlagUsTold  = 3;

  // Result queue depth (power of two, at least three)
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [2:0] {
    PhData  = 3'd0,
    PhIac   = 3'd1,
    PhWill  = 3'd2,
    PhWont  = 3'd3,
    PhDo    = 3'd4,
    PhDont  = 3'd5,
    PhSb    = 3'd6,
    PhSbIac = 3'd7
  } phase_e;

  typedef struct packed {
    logic       to_network;
    logic [7:0] byte_value;
    logic       last_of_run;
    logic       echo_locally;
  } res_t;

  // Up to three results caused by one item
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      res;
  } batch_t;

endpackage

// ===== design/telnet_receive_demux_negotiator.sv =====
// Channel  | Handshake                    | Payload
// receive  | rx_valid_i / rx_ready_o      | rx_byte_i
// result   | res_valid_o / res_ready_i    | to_network_o, byte_value_o,
//          |                              | last_of_run_o, echo_locally_o
//
// One item is taken per cycle while the queue has room. Each item gives up to
// three results into a four-entry queue that drains one result per cycle
// while res_ready_i is set, so a three-byte reply may stall the receive side.
// Reset clears the parser state and the option store valid bits at once:
// no clearing pass, items are taken from the first cycle after reset.
// A stalled result side holds the item in the input register.
module telnet_receive_demux_negotiator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       to_network_o,
  output logic [7:0] byte_value_o,
  output logic       last_of_run_o,
  output logic       echo_locally_o
);
  import tdn_pkg::*;

  batch_t             batch;
  logic               push;
  logic [OutCntW-1:0] room;
  res_t               res;

  tdn_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .room_i     (room),
    .push_o     (push),
    .batch_o    (batch)
  );

  tdn_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .batch_i     (batch),
    .room_o      (room),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res)
  );

  assign to_network_o   = res.to_network;
  assign byte_value_o   = res.byte_value;
  assign last_of_run_o  = res.last_of_run;
  assign echo_locally_o = res.echo_locally;

endmodule

// ===== design/tdn_ram.sv =====
module tdn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tdn_core.sv =====
module tdn_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rx_valid_i,
  output logic            rx_ready_o,
  input  logic [7:0]      rx_byte_i,
  input  logic [tdn_pkg::OutCntW-1:0] room_i,
  output logic            push_o,
  output tdn_pkg::batch_t batch_o
);
  import tdn_pkg::*;

  logic               s1_valid_q;
  logic [7:0]         byte_q;
  logic               rd_vld_q;
  logic [NumOpts-1:0] opt_vld_q;
  logic [FlagW-1:0]   rd_flags;
  phase_e             phase_q, phase_d;
  logic               cr_q, cr_d;
  logic               echo_q, echo_d;
  logic               accept;
  logic               fire;

  logic [FlagW-1:0]   flags;
  logic [FlagW-1:0]   flags_new;
  logic               us_side, want_on, acceptable, grant, is_on, told, skip;
  logic               neg_phase;
  logic               ram_we;
  logic [7:0]         verb;

  logic [1:0]         cnt;
  logic [2:0]         s_net;
  logic [2:0][7:0]    s_val;

  assign accept = rx_valid_i && rx_ready_o;
  assign fire   = s1_valid_q && ({{(OutCntW-2){1'b0}}, cnt} <= room_i);
  assign rx_ready_o = !s1_valid_q || fire;
  assign push_o = fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      s1_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q   <= rx_byte_i;
      rd_vld_q <= opt_vld_q[rx_byte_i];
    end
  end

  // Option store, read as each item is taken
  tdn_ram #(
    .Width (FlagW),
    .Depth (NumOpts)
  ) u_opt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_q),
    .wdata_i (flags_new),
    .re_i    (accept),
    .raddr_i (rx_byte_i),
    .rdata_o (rd_flags)
  );

  // Entry valid bits: an unwritten option reads as cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_vld_q <= '0;
    end else if (ram_we) begin
      opt_vld_q[byte_q] <= 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhData;
      cr_q    <= 1'b0;
      echo_q  <= 1'b1;
    end else if (fire) begin
      phase_q <= phase_d;
      cr_q    <= cr_d;
      echo_q  <= echo_d;
    end
  end

  // Negotiation decision for the option byte
  always_comb begin
    flags      = rd_vld_q ? rd_flags : '0;
    neg_phase  = (phase_q == PhWill) || (phase_q == PhWont) ||
                 (phase_q == PhDo)   || (phase_q == PhDont);
    us_side    = (phase_q == PhDo) || (phase_q == PhDont);
    want_on    = (phase_q == PhWill) || (phase_q == PhDo);
    case (phase_q)
      PhWill:  acceptable = (byte_q == OptEcho) || (byte_q == OptSga);
      PhDo:    acceptable = (byte_q == OptSga);
      default: acceptable = 1'b0;
    endcase
    grant = want_on && acceptable;
    is_on = us_side ? flags[FlagUs] : flags[FlagHim];
    told  = us_side ? flags[FlagUsTold] : flags[FlagHimTold];
    skip  = told && (is_on == grant);
    flags_new = flags;
    if (us_side) begin
      flags_new[FlagUsTold] = 1'b1;
      flags_new[FlagUs]     = grant;
    end else begin
      flags_new[FlagHimTold] = 1'b1;
      flags_new[FlagHim]     = grant;
    end
    if (us_side) begin
      verb = grant ? CmdWill : CmdWont;
    end else begin
      verb = grant ? CmdDo : CmdDont;
    end
  end

  assign ram_we = fire && neg_phase && !skip;

  // Next state and results for the held item
  always_comb begin
    phase_d = phase_q;
    cr_d    = cr_q;
    echo_d  = echo_q;
    cnt     = 2'd0;
    s_net   = '0;
    s_val   = '0;
    case (phase_q)
      PhData: begin
        if (byte_q == CmdIac) begin
          phase_d = PhIac;
        end else if (cr_q) begin
          cr_d = 1'b0;
          if (byte_q == ChNul) begin
            cnt = 2'd1; s_val[0] = ChCr;
          end else if (byte_q == ChLf) begin
            cnt = 2'd1; s_val[0] = ChLf;
          end else if (byte_q == ChCr) begin
            // CR CR: pass the first, hold the second
            cnt = 2'd1; s_val[0] = ChCr; cr_d = 1'b1;
          end else begin
            cnt = 2'd2; s_val[0] = ChCr; s_val[1] = byte_q;
          end
        end else if (byte_q == ChCr) begin
          cr_d = 1'b1;
        end else begin
          cnt = 2'd1; s_val[0] = byte_q;
        end
      end
      PhIac: begin
        case (byte_q)
          CmdIac: begin
            cnt = 2'd1; s_val[0] = CmdIac; phase_d = PhData;
          end
          CmdWill: phase_d = PhWill;
          CmdWont: phase_d = PhWont;
          CmdDo:   phase_d = PhDo;
          CmdDont: phase_d = PhDont;
          CmdSb:   phase_d = PhSb;
          default: phase_d = PhData;
        endcase
      end
      PhWill, PhWont, PhDo, PhDont: begin
        phase_d = PhData;
        if (!skip) begin
          cnt   = 2'd3;
          s_net = 3'b111;
          s_val[0] = CmdIac;
          s_val[1] = verb;
          s_val[2] = byte_q;
          if (byte_q == OptEcho && phase_q == PhWill) begin
            echo_d = 1'b0;
          end
          if (byte_q == OptEcho && phase_q == PhWont) begin
            echo_d = 1'b1;
          end
        end
      end
      PhSb: begin
        if (byte_q == CmdIac) begin
          phase_d = PhSbIac;
        end
      end
      default: begin
        phase_d = (byte_q == CmdSe) ? PhData : PhSb;
      end
    endcase
  end

  // Pack the results
  always_comb begin
    batch_o.cnt = cnt;
    for (int i = 0; i < 3; i++) begin
      batch_o.res[i].to_network   = s_net[i];
      batch_o.res[i].byte_value   = s_val[i];
      batch_o.res[i].last_of_run  = ((2'(i) + 2'd1) == cnt);
      batch_o.res[i].echo_locally = echo_d;
    end
  end

  // Option byte always ends the command
  a_neg_to_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && neg_phase |=> phase_q == PhData)
    else $error("negotiation did not return to data phase");

  // Store is written only for an answered request, which sends three bytes
  a_we_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt == 2'd3) && neg_phase)
    else $error("option store written without a reply");

  // Nothing leaves the input register without room for its results
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> ({{(OutCntW-2){1'b0}}, cnt} <= room_i))
    else $error("results pushed without room");

endmodule

// ===== design/tdn_res_fifo.sv =====
module tdn_res_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  tdn_pkg::batch_t             batch_i,
  output logic [tdn_pkg::OutCntW-1:0] room_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tdn_pkg::res_t               res_o
);
  import tdn_pkg::*;

  res_t               mem_q [OutDepth];
  logic [OutPtrW-1:0] head_q, tail_q;
  logic [OutCntW-1:0] count_q;
  logic               pop;
  logic [OutCntW-1:0] n_push;

  assign pop         = res_valid_o && res_ready_i;
  assign res_valid_o = (count_q != '0);
  assign res_o       = mem_q[head_q];
  assign n_push      = push_i ? {{(OutCntW-2){1'b0}}, batch_i.cnt} : '0;
  assign room_o      = OutCntW'(OutDepth) - count_q + {{(OutCntW-1){1'b0}}, pop};

  // Store the pushed results at the tail
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (push_i && (2'(i) < batch_i.cnt)) begin
        mem_q[tail_q + OutPtrW'(i)] <= batch_i.res[i];
      end
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + OutPtrW'(pop);
      tail_q  <= tail_q + OutPtrW'(n_push);
      count_q <= count_q + n_push - {{(OutCntW-1){1'b0}}, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OutCntW'(OutDepth))
    else $error("result queue overflow");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdn_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldOffLen  = 300;
  localparam int unsigned RandomItems = 350;
  localparam int unsigned IdlePct     = 22;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i   = 8'd0;
  logic       res_valid_o;
  logic       res_ready_i = 1'b0;
  logic       to_network_o;
  logic [7:0] byte_value_o;
  logic       last_of_run_o;
  logic       echo_locally_o;

  telnet_receive_demux_negotiator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .to_network_o  (to_network_o),
    .byte_value_o  (byte_value_o),
    .last_of_run_o (last_of_run_o),
    .echo_locally_o(echo_locally_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Mirror of the parser and option negotiation state
  phase_e             rx_phase = PhData;
  bit                 cr_held  = 1'b0;
  bit                 echo_on  = 1'b1;
  logic [FlagW-1:0]   opt_flags [NumOpts];
  bit                 run_net [3];
  logic [7:0]         run_val [3];
  int                 run_n;

  logic [7:0] rx_plan [$];
  res_t       expected_res [$];

  int unsigned n_rx_sent    = 0;
  int unsigned n_rx_taken   = 0;
  int unsigned n_res_seen   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_cnt     = 0;
  bit          hold_done    = 1'b0;

  function automatic void add_run(input bit net, input logic [7:0] val);
    if (run_n < 3) begin
      run_net[run_n] = net;
      run_val[run_n] = val;
      run_n++;
    end
  endfunction

  // Answer a request unless it was already answered in the same sense
  function automatic bit answer_request(input logic [7:0] opt, input bit us_side,
                                        input bit want_on, input bit acceptable);
    logic [FlagW-1:0] f;
    int unsigned      on_bit;
    int unsigned      told_bit;
    bit               grant;
    on_bit   = us_side ? FlagUs : FlagHim;
    told_bit = us_side ? FlagUsTold : FlagHimTold;
    f        = opt_flags[opt];
    grant    = want_on && acceptable;
    if (f[told_bit] && (f[on_bit] == grant)) return 1'b0;
    f[told_bit]    = 1'b1;
    f[on_bit]      = grant;
    opt_flags[opt] = f;
    add_run(1'b1, CmdIac);
    if (us_side) add_run(1'b1, grant ? CmdWill : CmdWont);
    else add_run(1'b1, grant ? CmdDo : CmdDont);
    add_run(1'b1, opt);
    return 1'b1;
  endfunction

  // Work out the results of one received byte and queue them
  function automatic void decode_rx_byte(input logic [7:0] c);
    res_t r;
    int   k;
    run_n = 0;
    case (rx_phase)
      PhData: begin
        if (c == CmdIac) begin
          rx_phase = PhIac;
        end else begin
          if (cr_held) begin
            cr_held = 1'b0;
            if (c == ChNul) add_run(1'b0, ChCr);
            else if (c == ChLf) add_run(1'b0, ChLf);
            else add_run(1'b0, ChCr);
          end
          if (run_n == 0 || (c != ChNul && c != ChLf)) begin
            if (c == ChCr) cr_held = 1'b1;
            else if (!(run_n == 1 && (c == ChNul || c == ChLf))) add_run(1'b0, c);
          end
        end
      end
      PhIac: begin
        if (c == CmdIac) begin
          add_run(1'b0, CmdIac);
          rx_phase = PhData;
        end else if (c == CmdWill) rx_phase = PhWill;
        else if (c == CmdWont) rx_phase = PhWont;
        else if (c == CmdDo) rx_phase = PhDo;
        else if (c == CmdDont) rx_phase = PhDont;
        else if (c == CmdSb) rx_phase = PhSb;
        else rx_phase = PhData;
      end
      PhWill: begin
        if (answer_request(c, 1'b0, 1'b1, c == OptEcho || c == OptSga) && c == OptEcho)
          echo_on = 1'b0;
        rx_phase = PhData;
      end
      PhWont: begin
        // local echo comes back only when a reply goes out
        if (answer_request(c, 1'b0, 1'b0, 1'b0) && c == OptEcho) echo_on = 1'b1;
        rx_phase = PhData;
      end
      PhDo: begin
        void'(answer_request(c, 1'b1, 1'b1, c == OptSga));
        rx_phase = PhData;
      end
      PhDont: begin
        void'(answer_request(c, 1'b1, 1'b0, 1'b0));
        rx_phase = PhData;
      end
      PhSb: begin
        if (c == CmdIac) rx_phase = PhSbIac;
      end
      default: begin
        rx_phase = (c == CmdSe) ? PhData : PhSb;
      end
    endcase
    for (k = 0; k < run_n; k++) begin
      r.to_network   = run_net[k];
      r.byte_value   = run_val[k];
      r.last_of_run  = (k == run_n - 1);
      r.echo_locally = echo_on;
      expected_res.push_back(r);
    end
  endfunction

  function automatic void plan_cmd(input logic [7:0] verb, input logic [7:0] opt);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(verb);
    rx_plan.push_back(opt);
  endfunction

  // Predict on every accepted byte, check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        decode_rx_byte(rx_byte_i);
        n_rx_taken++;
      end
      if (res_valid_o && res_ready_i) begin
        n_res_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result, expected none, got net=%0b byte=%0h last=%0b echo=%0b",
                   $time, to_network_o, byte_value_o, last_of_run_o, echo_locally_o);
          mismatch_cnt++;
        end else begin
          if (to_network_o !== expected_res[0].to_network) begin
            $display("%0t: to_network expected %0b got %0b", $time,
                     expected_res[0].to_network, to_network_o);
            mismatch_cnt++;
          end
          if (byte_value_o !== expected_res[0].byte_value) begin
            $display("%0t: byte_value expected %0h got %0h", $time,
                     expected_res[0].byte_value, byte_value_o);
            mismatch_cnt++;
          end
          if (last_of_run_o !== expected_res[0].last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b", $time,
                     expected_res[0].last_of_run, last_of_run_o);
            mismatch_cnt++;
          end
          if (echo_locally_o !== expected_res[0].echo_locally) begin
            $display("%0t: echo_locally expected %0b got %0b", $time,
                     expected_res[0].echo_locally, echo_locally_o);
            mismatch_cnt++;
          end
          void'(expected_res.pop_front());
        end
      end
    end
  end

  // Feed bytes from the plan; a stretch in the middle runs without gaps
  always @(negedge clk_i) begin
    if (rst_ni && n_rx_taken == n_rx_sent) begin
      if (rx_plan.size() > 0 &&
          ((n_rx_sent >= 120 && n_rx_sent < 220) || $urandom_range(99) >= IdlePct)) begin
        rx_valid_i <= 1'b1;
        rx_byte_i  <= rx_plan.pop_front();
        n_rx_sent++;
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
  end

  // Drain results; hold off once for a long stretch to back up the input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_res_seen >= 60) begin
        hold_done <= 1'b1;
        hold_cnt  <= HoldOffLen;
        res_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= (n_res_seen >= 150 && n_res_seen < 260) ||
                       ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && rx_ready_o) || (res_valid_o && res_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned directed_n;
    int unsigned pick;
    int unsigned k;
    int unsigned len;
    logic [7:0]  b;

    for (k = 0; k < NumOpts; k++) opt_flags[k] = '0;

    // Directed: data extremes, line endings, escapes, negotiation, subnegotiation
    rx_plan.push_back(8'h00);
    rx_plan.push_back(8'hFE);
    rx_plan.push_back(ChCr);
    rx_plan.push_back(ChNul);
    rx_plan.push_back(ChCr);
    rx_plan.push_back(ChCr);
    rx_plan.push_back(ChLf);
    // CR held across an unknown command, then resolved by a plain byte
    rx_plan.push_back(ChCr);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(8'd241);
    rx_plan.push_back(8'h41);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(CmdIac);
    plan_cmd(CmdWill, OptEcho);
    plan_cmd(CmdWill, OptEcho);
    plan_cmd(CmdWont, OptEcho);
    plan_cmd(CmdDo, OptSga);
    plan_cmd(CmdDont, 8'hFF);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(CmdSb);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(CmdIac);
    rx_plan.push_back(CmdSe);
    directed_n = rx_plan.size();

    // Random: mostly well-formed sequences with random content, some noise
    while (rx_plan.size() < directed_n + RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        rx_plan.push_back(8'($urandom_range(254)));
      end else if (pick < 50) begin
        rx_plan.push_back(ChCr);
        case ($urandom_range(3))
          0: rx_plan.push_back(ChNul);
          1: rx_plan.push_back(ChLf);
          2: rx_plan.push_back(ChCr);
          default: rx_plan.push_back(8'($urandom_range(254)));
        endcase
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0: b = CmdWill;
          1: b = CmdWont;
          2: b = CmdDo;
          default: b = CmdDont;
        endcase
        if ($urandom_range(9) < 6) plan_cmd(b, $urandom_range(1) ? OptEcho : OptSga);
        else plan_cmd(b, 8'($urandom_range(255)));
      end else if (pick < 83) begin
        rx_plan.push_back(CmdIac);
        rx_plan.push_back(CmdIac);
      end else if (pick < 90) begin
        rx_plan.push_back(CmdIac);
        rx_plan.push_back(CmdSb);
        len = $urandom_range(4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(4) == 0) begin
            rx_plan.push_back(CmdIac);
            rx_plan.push_back(CmdIac);
          end else begin
            rx_plan.push_back(8'($urandom_range(254)));
          end
        end
        rx_plan.push_back(CmdIac);
        rx_plan.push_back(CmdSe);
      end else if (pick < 95) begin
        rx_plan.push_back(CmdIac);
        rx_plan.push_back($urandom_range(1) ? 8'($urandom_range(241, 249))
                                            : 8'($urandom_range(239)));
      end else begin
        rx_plan.push_back(8'($urandom_range(255)));
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to go in and every result to come out
    while (rx_plan.size() > 0 || n_rx_taken != n_rx_sent || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tdn_pkg.sv
design/tdn_ram.sv
design/tdn_core.sv
design/tdn_res_fifo.sv
design/telnet_receive_demux_negotiator.sv
tb/sv/tb.sv
